// ----- rtl/core/ovle_pkg.sv -----
// ----------------------------------------------------------------------------
// ovle_pkg
// Shared types and constants of the ordered value list engine.
// ----------------------------------------------------------------------------
package ovle_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT    = 3'd0,
    ACT_PUSH_BACK     = 3'd1,
    ACT_INSERT_BEFORE = 3'd2,
    ACT_REMOVE_VALUE  = 3'd3,
    ACT_POP_FRONT     = 3'd4,
    ACT_POP_BACK      = 3'd5,
    ACT_QUERY         = 3'd6,
    ACT_CLEAR         = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_HEAD  = 2'd1,
    HIT_SLOT  = 2'd2,
    HIT_MATCH = 2'd3
  } hit_sel_e;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } shift_mode_e;

  typedef struct packed {
    logic        capture;
    logic        update;
    hit_sel_e    sel;
    shift_mode_e mode;
  } cell_ctrl_t;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] value;
    logic signed [31:0] target;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
    logic [4:0]         count;
  } rsp_t;

endpackage

// ----- rtl/core/ovle_cell.sv -----
// ----------------------------------------------------------------------------
// ovle_cell
// One list slot: holds an entry, flags a hit, shifts with its neighbors.
// ----------------------------------------------------------------------------
module ovle_cell import ovle_pkg::*; #(
  parameter int unsigned CAPACITY = ovle_pkg::CAPACITY,
  parameter int unsigned IDX      = 0,
  localparam int unsigned OCC_W   = $clog2(CAPACITY + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] key_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [OCC_W-1:0]  occ_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  input  logic              prior_i,
  output logic              prior_o,
  output logic [DATA_W-1:0] entry_o,
  output logic [DATA_W-1:0] tail_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              hit_q, hit_d;
  logic              first;

  always_comb begin
    case (ctrl_i.sel)
      HIT_HEAD:  hit_d = (IDX == 0);
      HIT_SLOT:  hit_d = (occ_i == OCC_W'(IDX));
      HIT_MATCH: hit_d = (entry_q == key_i) && (OCC_W'(IDX) < occ_i);
      default:   hit_d = 1'b0;
    endcase
  end

  assign first   = hit_q & ~prior_i;
  assign prior_o = prior_i | hit_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.update) begin
      case (ctrl_i.mode)
        MODE_INSERT: begin
          if (first) begin
            entry_d = value_i;
          end else if (prior_i) begin
            entry_d = left_i;
          end
        end
        MODE_REMOVE: begin
          if (first || prior_i) begin
            entry_d = right_i;
          end
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign tail_o  = (occ_i == OCC_W'(IDX + 1)) ? entry_q : '0;

endmodule

// ----- rtl/core/ordered_value_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_value_list_engine_unit
// Ordered list of signed values kept packed in a row of slot cells.
// A request passes the match, shift and tally states over the cell row; the
// result is registered on leaving tally, which waits while the output stalls.
// The next request is taken as the result is registered, not before.
// Reset clears the occupancy and control state; slot contents stay undefined.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_unit import ovle_pkg::*; #(
  parameter int unsigned CAPACITY = ovle_pkg::CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_TALLY = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [OCC_W-1:0]  occ_q, occ_d;
  status_e           status_q, status_d;
  rsp_t              rsp_q, rsp_d;
  logic              out_valid_q;

  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] entry_w [CAPACITY];
  logic [DATA_W-1:0] tail_w [CAPACITY];
  logic              prior_w [CAPACITY+1];
  logic [DATA_W-1:0] tail_all;
  logic              full, empty, found, load_out, in_beat;

  assign full     = (occ_q == OCC_W'(CAPACITY));
  assign empty    = (occ_q == '0);
  assign found    = prior_w[CAPACITY];
  assign load_out = (state_q == ST_TALLY) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE) || load_out;
  assign in_beat  = in_valid_i && in_ready_o;

  always_comb begin
    ctrl.capture = (state_q == ST_MATCH);
    ctrl.update  = (state_q == ST_SHIFT);
    ctrl.sel     = HIT_NONE;
    ctrl.mode    = MODE_NONE;
    key          = req_q.value;
    case (req_q.action)
      ACT_PUSH_FRONT: begin
        ctrl.sel  = full ? HIT_NONE : HIT_HEAD;
        ctrl.mode = MODE_INSERT;
      end
      ACT_PUSH_BACK: begin
        ctrl.sel  = full ? HIT_NONE : HIT_SLOT;
        ctrl.mode = MODE_INSERT;
      end
      ACT_INSERT_BEFORE: begin
        ctrl.sel  = full ? HIT_NONE : HIT_MATCH;
        ctrl.mode = MODE_INSERT;
        key       = req_q.target;
      end
      ACT_REMOVE_VALUE: begin
        ctrl.sel  = HIT_MATCH;
        ctrl.mode = MODE_REMOVE;
      end
      ACT_POP_FRONT: begin
        ctrl.sel  = empty ? HIT_NONE : HIT_HEAD;
        ctrl.mode = MODE_REMOVE;
      end
      default: begin
        ctrl.sel  = HIT_NONE;
        ctrl.mode = MODE_NONE;
      end
    endcase
  end

  assign prior_w[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned L = (i == 0) ? 0 : i - 1;
    localparam int unsigned R = (i == CAPACITY - 1) ? i : i + 1;
    ovle_cell #(
      .CAPACITY(CAPACITY),
      .IDX     (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .key_i  (key),
      .value_i(req_q.value),
      .occ_i  (occ_q),
      .left_i (entry_w[L]),
      .right_i(entry_w[R]),
      .prior_i(prior_w[i]),
      .prior_o(prior_w[i+1]),
      .entry_o(entry_w[i]),
      .tail_o (tail_w[i])
    );
  end

  always_comb begin
    tail_all = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_all = tail_all | tail_w[i];
    end
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = status_q;
    if (state_q == ST_SHIFT) begin
      status_d = STS_OK;
      case (req_q.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_BEFORE: begin
          if (full) begin
            status_d = STS_FULL;
          end else if (found) begin
            occ_d = occ_q + OCC_W'(1);
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
        ACT_REMOVE_VALUE: begin
          if (found) begin
            occ_d = occ_q - OCC_W'(1);
          end else begin
            status_d = STS_NOT_FOUND;
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (empty) begin
            status_d = STS_EMPTY;
          end else begin
            occ_d = occ_q - OCC_W'(1);
          end
        end
        ACT_CLEAR: occ_d = '0;
        default:   occ_d = occ_q;
      endcase
    end
  end

  always_comb begin
    rsp_d.status      = status_q;
    rsp_d.first_value = empty ? '1 : entry_w[0];
    rsp_d.last_value  = empty ? '1 : tail_all;
    rsp_d.count       = COUNT_W'(occ_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_beat) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_TALLY;
      ST_TALLY: begin
        if (load_out) begin
          state_d = in_beat ? ST_MATCH : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      status_q    <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      status_q <= status_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      req_q <= in_req_i;
    end
    if (load_out) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
